// File: rtl/chxy_pkg.sv
// ============================================================================
// chxy_pkg
// Types, constants and the arctangent table for the compass heading block.
// ============================================================================
package chxy_pkg;

  // Requested CORDIC iteration count and the size of the arctangent table
  localparam int CORDIC_STAGES = 18;
  localparam int TABLE_LEN     = 24;
  localparam int NUM_STAGES    = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

  // Fixed-point formats
  localparam int PRE_SHIFT   = 8;      // magnitude scaling ahead of the CORDIC
  localparam int SAMPLE_W    = 16;
  localparam int OFFSET_W    = 13;
  localparam int ADJ_W       = 18;     // offset-corrected sample, signed
  localparam int MAG_W       = 17;     // magnitude of the corrected sample
  localparam int CW          = 27;     // CORDIC x/y datapath, signed
  localparam int ZW          = 25;     // angle in degrees, 16 fraction bits
  localparam int FRAC_W      = 16;
  localparam int DEG_W       = 9;
  localparam int ASCII_W     = 6;
  localparam int ANG_ONE_DEG = 65536;

  localparam logic [ZW-1:0]      ANG_90   = ZW'(90 * ANG_ONE_DEG);
  localparam logic [ZW-1:0]      ANG_180  = ZW'(180 * ANG_ONE_DEG);
  localparam logic [ZW-1:0]      ANG_360  = ZW'(360 * ANG_ONE_DEG);
  localparam logic [DEG_W-1:0]   DEG_MAX  = DEG_W'(359);
  localparam logic [ASCII_W-1:0] ASCII_0  = ASCII_W'(8'h30);

  // Configuration register indexes
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET = CFG_IDX_W'(1);

  localparam logic signed [OFFSET_W-1:0] X_OFFSET_RESET = OFFSET_W'(10);
  localparam logic signed [OFFSET_W-1:0] Y_OFFSET_RESET = OFFSET_W'(-10);

  // One input item
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x_sample;
    logic signed [SAMPLE_W-1:0] y_sample;
  } chxy_in_t;

  // One result item
  typedef struct packed {
    logic [DEG_W-1:0]   heading_deg;
    logic [ASCII_W-1:0] ascii_hundreds;
    logic [ASCII_W-1:0] ascii_tens;
    logic [ASCII_W-1:0] ascii_ones;
  } chxy_out_t;

  // Quadrant and axis flags that travel beside the CORDIC data
  typedef struct packed {
    logic n_neg;
    logic d_neg;
    logic n_zero;
    logic d_zero;
  } chxy_quad_t;

  // Arctangent of 2^-idx in degrees, 16 fraction bits, rounded to nearest
  function automatic logic [ZW-1:0] atan_q16(input int unsigned idx);
    logic [ZW-1:0] val;
    case (idx)
      0:       val = ZW'(2949120);
      1:       val = ZW'(1740967);
      2:       val = ZW'(919879);
      3:       val = ZW'(466945);
      4:       val = ZW'(234379);
      5:       val = ZW'(117304);
      6:       val = ZW'(58666);
      7:       val = ZW'(29335);
      8:       val = ZW'(14668);
      9:       val = ZW'(7334);
      10:      val = ZW'(3667);
      11:      val = ZW'(1833);
      12:      val = ZW'(917);
      13:      val = ZW'(458);
      14:      val = ZW'(229);
      15:      val = ZW'(115);
      16:      val = ZW'(57);
      17:      val = ZW'(29);
      18:      val = ZW'(14);
      19:      val = ZW'(7);
      20:      val = ZW'(4);
      21:      val = ZW'(2);
      22:      val = ZW'(1);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// File: rtl/compass_heading_from_xy.sv
// ============================================================================
// compass_heading_from_xy
// Pipelined CORDIC heading of one magnetometer x/y pair, in degrees and ASCII.
// ============================================================================
// Usage:
//   Input channel: drive sample and raise start; the item is taken at any
//   rising edge with start high and busy low. busy stays low, so one item
//   may be issued in every cycle.
//   Result channel: done is high for exactly one cycle with the result on
//   heading. The receiver cannot stall; nothing is held back.
//   Configuration channel: cfg_valid with cfg_index and cfg_data writes
//   x_offset (index 0) or y_offset (index 1); cfg_ready is always high and
//   other indexes are ignored. Write only while no item is in flight.
//   Path from start to done: an input register, one register per CORDIC
//   iteration, a quadrant fix-up register, a hundreds-digit register and
//   the output register. Throughput is one item per cycle.
//   Reset (rst, synchronous): clears every pipeline valid bit, so items in
//   flight are dropped, and loads offsets 10 and -10.
// ============================================================================
module compass_heading_from_xy (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  chxy_pkg::chxy_in_t                sample,
  output logic                              done,
  output chxy_pkg::chxy_out_t               heading,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [chxy_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [chxy_pkg::OFFSET_W-1:0]     cfg_data
);
  import chxy_pkg::*;

  localparam int LATENCY = NUM_STAGES + 4;

  // Configuration registers
  logic signed [OFFSET_W-1:0] x_off;
  logic signed [OFFSET_W-1:0] y_off;

  // CORDIC pipeline, index 0 is the input register
  logic                 vld  [0:NUM_STAGES];
  logic signed [CW-1:0] cx   [0:NUM_STAGES];
  logic signed [CW-1:0] cy   [0:NUM_STAGES];
  logic signed [ZW-1:0] zs   [0:NUM_STAGES];
  chxy_quad_t           quad [0:NUM_STAGES];

  // Input stage signals
  logic signed [ADJ_W-1:0] n_adj;
  logic signed [ADJ_W-1:0] d_adj;
  logic [ADJ_W-1:0]        n_abs;
  logic [ADJ_W-1:0]        d_abs;
  logic                    accept;

  // Back-end stages
  logic                 fix_vld;
  logic [DEG_W-1:0]     fix_deg;
  logic [ZW-1:0]        ang_a;
  logic [ZW-1:0]        ang_h;
  logic [DEG_W-1:0]     deg_next;
  logic                 dig_vld;
  logic [DEG_W-1:0]     dig_deg;
  logic [1:0]           dig_hund;
  logic [6:0]           dig_rem;
  logic [1:0]           hund_next;
  logic [6:0]           rem_next;
  logic [14:0]          tens_prod;
  logic [3:0]           tens_val;
  logic [3:0]           ones_val;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Write offset registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      x_off <= X_OFFSET_RESET;
      y_off <= Y_OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_X_OFFSET) begin
        x_off <= $signed(cfg_data);
      end else if (cfg_index == REG_Y_OFFSET) begin
        y_off <= $signed(cfg_data);
      end
    end
  end

  // Subtract offsets and take magnitudes
  always_comb begin
    n_adj = ADJ_W'(sample.x_sample) - ADJ_W'(x_off);
    d_adj = ADJ_W'(sample.y_sample) - ADJ_W'(y_off);
    n_abs = n_adj[ADJ_W-1] ? ADJ_W'(-n_adj) : ADJ_W'(n_adj);
    d_abs = d_adj[ADJ_W-1] ? ADJ_W'(-d_adj) : ADJ_W'(d_adj);
  end

  // Load the input register with scaled magnitudes and quadrant flags
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= accept;
    end
    cx[0]          <= $signed({{(CW-MAG_W-PRE_SHIFT){1'b0}}, d_abs[MAG_W-1:0],
                               {PRE_SHIFT{1'b0}}});
    cy[0]          <= $signed({{(CW-MAG_W-PRE_SHIFT){1'b0}}, n_abs[MAG_W-1:0],
                               {PRE_SHIFT{1'b0}}});
    zs[0]          <= '0;
    quad[0].n_neg  <= n_adj[ADJ_W-1];
    quad[0].d_neg  <= d_adj[ADJ_W-1];
    quad[0].n_zero <= (n_adj == '0);
    quad[0].d_zero <= (d_adj == '0);
  end

  // One vectoring iteration per stage, rotating y toward zero
  for (genvar k = 1; k <= NUM_STAGES; k++) begin : g_cordic
    localparam int SH = k - 1;
    logic signed [CW-1:0] tx;
    logic signed [CW-1:0] ty;
    logic signed [ZW-1:0] step;

    assign tx   = cx[k-1] >>> SH;
    assign ty   = cy[k-1] >>> SH;
    assign step = $signed(atan_q16(SH));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
      if (cy[k-1] > 0) begin
        cx[k] <= cx[k-1] + ty;
        cy[k] <= cy[k-1] - tx;
        zs[k] <= zs[k-1] + step;
      end else begin
        cx[k] <= cx[k-1] - ty;
        cy[k] <= cy[k-1] + tx;
        zs[k] <= zs[k-1] - step;
      end
      quad[k] <= quad[k-1];
    end
  end

  // Clamp the first-quadrant angle, apply axis cases and the quadrant fold
  always_comb begin
    if (quad[NUM_STAGES].n_zero) begin
      ang_a = '0;
    end else if (quad[NUM_STAGES].d_zero) begin
      ang_a = ANG_90;
    end else if (zs[NUM_STAGES][ZW-1]) begin
      ang_a = '0;
    end else if (zs[NUM_STAGES] > $signed(ANG_90)) begin
      ang_a = ANG_90;
    end else begin
      ang_a = ZW'(zs[NUM_STAGES]);
    end
    case ({quad[NUM_STAGES].d_neg, quad[NUM_STAGES].n_neg})
      2'b00:   ang_h = ang_a;
      2'b10:   ang_h = ANG_180 - ang_a;
      2'b11:   ang_h = ANG_180 + ang_a;
      default: ang_h = ANG_360 - ang_a;
    endcase
    deg_next = ang_h[ZW-1 -: DEG_W];
    if (deg_next > DEG_MAX) begin
      deg_next = DEG_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fix_vld <= 1'b0;
    end else begin
      fix_vld <= vld[NUM_STAGES];
    end
    fix_deg <= deg_next;
  end

  // Split off the hundreds digit
  always_comb begin
    if (fix_deg >= DEG_W'(300)) begin
      hund_next = 2'd3;
      rem_next  = 7'(fix_deg - DEG_W'(300));
    end else if (fix_deg >= DEG_W'(200)) begin
      hund_next = 2'd2;
      rem_next  = 7'(fix_deg - DEG_W'(200));
    end else if (fix_deg >= DEG_W'(100)) begin
      hund_next = 2'd1;
      rem_next  = 7'(fix_deg - DEG_W'(100));
    end else begin
      hund_next = 2'd0;
      rem_next  = 7'(fix_deg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dig_vld <= 1'b0;
    end else begin
      dig_vld <= fix_vld;
    end
    dig_deg  <= fix_deg;
    dig_hund <= hund_next;
    dig_rem  <= rem_next;
  end

  // Tens by reciprocal multiply (exact below 100), ones by remainder
  always_comb begin
    tens_prod = 15'(dig_rem) * 15'd205;
    tens_val  = tens_prod[14:11];
    ones_val  = 4'(dig_rem - 7'(tens_val * 4'd10));
  end

  // Drive the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dig_vld;
    end
    heading.heading_deg    <= dig_deg;
    heading.ascii_hundreds <= ASCII_0 + ASCII_W'(dig_hund);
    heading.ascii_tens     <= ASCII_0 + ASCII_W'(tens_val);
    heading.ascii_ones     <= ASCII_0 + ASCII_W'(ones_val);
  end

  // Every accepted item yields a result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("accepted item did not produce a result on time");

  // No result without an item accepted the fixed latency earlier
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result strobe without a matching item");

  // Heading stays folded below a full turn
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (heading.heading_deg <= DEG_MAX))
    else $error("heading out of range");

  // ASCII digits agree with the binary heading
  a_digits: assert property (@(posedge clk) disable iff (rst)
    done |-> (heading.heading_deg ==
              DEG_W'(heading.ascii_hundreds - ASCII_0) * DEG_W'(100) +
              DEG_W'(heading.ascii_tens - ASCII_0) * DEG_W'(10) +
              DEG_W'(heading.ascii_ones - ASCII_0)))
    else $error("ASCII digits disagree with heading");

endmodule
